@@ rtl/core/sha_message_padder_unit_macros.svh @@
// Assertion macros shared by the message padder RTL.
// Depends on nothing; the including module supplies clk and rst_n.
`ifndef SHA_MESSAGE_PADDER_UNIT_MACROS_SVH
`define SHA_MESSAGE_PADDER_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SPAD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("padder check failed");

// Next-cycle implication, checked outside reset.
`define SPAD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("padder check failed");

`endif

@@ rtl/core/sha_pad_pkg.sv @@
// Shared widths, codes and constants of the message padder.
// Depends on nothing; used by sha_message_padder_unit.
`default_nettype none

package sha_pad_pkg;

    // Field and port widths.
    localparam int DATA_W      = 8;
    localparam int WORD_W      = 32;
    localparam int WIDX_W      = 5;
    localparam int CTRL_W      = 4;
    localparam int COUNT_W     = 128;
    localparam int OUT_TDATA_W = 48;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 2;
    localparam int CORE_MODE_W = 2;

    // Default storage size in bytes.
    localparam int MAX_BLOCK_BYTES_DEF = 128;

    // Input item kinds.
    localparam logic FUNC_DATA   = 1'b0;
    localparam logic FUNC_FINISH = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CORE_MODE  = 2'd1;

    // Core commands carried on the last word of a block.
    localparam logic [CTRL_W-1:0] CMD_NONE = 4'd0;
    localparam logic [CTRL_W-1:0] CMD_INIT = 4'd1;
    localparam logic [CTRL_W-1:0] CMD_NEXT = 4'd2;

    // Padding marker byte.
    localparam logic [DATA_W-1:0] PAD_BYTE = 8'h80;

endpackage

`default_nettype wire

@@ rtl/core/sha_message_padder_unit.sv @@
// SHA-2 message padder: collects bytes into 64/128-byte blocks and emits 32-bit words.
// Depends on sha_pad_pkg and sha_message_padder_unit_macros.svh.
// Flow: a data byte that leaves room in the block is stored and the block stays ready; the byte
// that fills it starts the emission, each word a memory read then an output beat that waits on m_tready.
// A finish beat stores the marker, then the zero and length bytes are written, then the emission;
// if the length does not fit, an extra length block is padded and emitted as well. One item at a time.
// Reset (rst_n, asynchronous, active low) clears counters and control; the store is not.
`default_nettype none

module sha_message_padder_unit #(
    parameter int MAX_BLOCK_BYTES = sha_pad_pkg::MAX_BLOCK_BYTES_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // Input stream: tdata = data_byte[7:0]; tuser = func.
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    input  wire logic [sha_pad_pkg::DATA_W-1:0]       s_tdata,
    input  wire logic                                 s_tuser,
    // Output stream: tdata = word[31:0], word_index[36:32], ctrl_code[40:37], zeros;
    // tlast = last; tuser = final_block.
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    output logic [sha_pad_pkg::OUT_TDATA_W-1:0]       m_tdata,
    output logic                                      m_tlast,
    output logic                                      m_tuser,
    // Configuration write port.
    input  wire logic                                 cfg_we,
    input  wire logic [sha_pad_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [sha_pad_pkg::CFG_DATA_W-1:0]   cfg_data
);

    `include "sha_message_padder_unit_macros.svh"

    localparam int   DEPTH   = MAX_BLOCK_BYTES / 4;
    localparam int   AW      = $clog2(DEPTH);
    localparam int   FW      = $clog2(MAX_BLOCK_BYTES + 1);
    localparam bit   WIDE_OK = (MAX_BLOCK_BYTES >= 128);
    localparam logic [FW-1:0] BLEN_NARROW = FW'(64);
    localparam logic [FW-1:0] BLEN_WIDE   = FW'(WIDE_OK ? 128 : 64);
    localparam logic [FW-1:0] LLEN_NARROW = FW'(8);
    localparam logic [FW-1:0] LLEN_WIDE   = FW'(16);
    localparam int   CW      = sha_pad_pkg::COUNT_W;
    localparam int   WW      = sha_pad_pkg::WORD_W;
    localparam int   XW      = sha_pad_pkg::WIDX_W;
    localparam int   KW      = sha_pad_pkg::CTRL_W;
    localparam int   BW      = sha_pad_pkg::DATA_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PAD,
        ST_EMIT_RD,
        ST_EMIT_OUT
    } state_t;

    state_t                 state_reg, state_next;
    logic [FW-1:0]          fill_reg, fill_next;
    logic [CW-1:0]          count_reg, count_next;
    logic                   first_reg, first_next;
    logic                   block_mode_reg, block_mode_next;
    logic [sha_pad_pkg::CORE_MODE_W-1:0] core_mode_reg, core_mode_next;
    logic [CW-1:0]          len_sr_reg, len_sr_next;
    logic                   extra_reg, extra_next;
    logic                   fin_reg, fin_next;
    logic [XW-1:0]          widx_reg, widx_next;
    logic                   out_valid_reg, out_valid_next;
    logic [XW-1:0]          out_index_reg, out_index_next;
    logic [KW-1:0]          out_ctrl_reg, out_ctrl_next;
    logic                   out_last_reg, out_last_next;
    logic                   out_final_reg, out_final_next;
    logic [WW-1:0]          out_word_reg;

    logic [WW-1:0]          block_store_mem [DEPTH];

    logic                   wide;
    logic [FW-1:0]          blen;
    logic [FW-1:0]          llen;
    logic [FW-1:0]          len_start;
    logic [FW-1:0]          fill_inc;
    logic [XW-1:0]          words_m1;
    logic                   accept;
    logic                   mem_we;
    logic [BW-1:0]          mem_wdata;

    // Block geometry for the current mode.
    assign wide      = block_mode_reg & WIDE_OK;
    assign blen      = wide ? BLEN_WIDE : BLEN_NARROW;
    assign llen      = wide ? LLEN_WIDE : LLEN_NARROW;
    assign len_start = blen - llen;
    assign fill_inc  = fill_reg + FW'(1);
    assign words_m1  = XW'((blen >> 2) - FW'(1));
    assign accept    = s_tvalid && s_tready;

    // Byte written into the store this cycle: message byte, marker, zero or length byte.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_wdata = '0;
        if (state_reg == ST_IDLE && accept)
        begin
            mem_we    = 1'b1;
            mem_wdata = (s_tuser == sha_pad_pkg::FUNC_FINISH) ? sha_pad_pkg::PAD_BYTE
                                                              : s_tdata;
        end
        else if (state_reg == ST_PAD && fill_reg != blen)
        begin
            mem_we = 1'b1;
            if (!extra_reg && fill_reg >= len_start)
            begin
                mem_wdata = len_sr_reg[CW-1 -: BW];
            end
        end
    end

    // Block store: byte-lane writes, registered word reads.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            unique case (fill_reg[1:0])
                2'd0: block_store_mem[fill_reg[AW+1:2]][31:24] <= mem_wdata;
                2'd1: block_store_mem[fill_reg[AW+1:2]][23:16] <= mem_wdata;
                2'd2: block_store_mem[fill_reg[AW+1:2]][15:8]  <= mem_wdata;
                2'd3: block_store_mem[fill_reg[AW+1:2]][7:0]   <= mem_wdata;
                default: ;
            endcase
        end
        if (state_reg == ST_EMIT_RD)
        begin
            out_word_reg <= block_store_mem[widx_reg[AW-1:0]];
        end
    end

    // Sequencer next-state logic; configuration writes are to land while idle, which the block does not enforce.
    always_comb
    begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        count_next      = count_reg;
        first_next      = first_reg;
        block_mode_next = block_mode_reg;
        core_mode_next  = core_mode_reg;
        len_sr_next     = len_sr_reg;
        extra_next      = extra_reg;
        fin_next        = fin_reg;
        widx_next       = widx_reg;
        out_valid_next  = out_valid_reg;
        out_index_next  = out_index_reg;
        out_ctrl_next   = out_ctrl_reg;
        out_last_next   = out_last_reg;
        out_final_next  = out_final_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (s_tuser == sha_pad_pkg::FUNC_DATA)
                    begin
                        count_next = count_reg + CW'(1);
                        extra_next = 1'b0;
                        if (fill_inc == blen)
                        begin
                            fill_next  = '0;
                            fin_next   = 1'b0;
                            widx_next  = '0;
                            state_next = ST_EMIT_RD;
                        end
                        else
                        begin
                            fill_next = fill_inc;
                        end
                    end
                    else
                    begin
                        // Bit length, most significant length byte at the top.
                        len_sr_next = wide ? {count_reg[CW-4:0], 3'b000}
                                           : {count_reg[60:0], 3'b000, 64'd0};
                        fill_next   = fill_inc;
                        extra_next  = (blen - fill_inc) < llen;
                        state_next  = ST_PAD;
                    end
                end
            end

            ST_PAD:
            begin
                if (fill_reg == blen)
                begin
                    fin_next   = !extra_reg;
                    widx_next  = '0;
                    state_next = ST_EMIT_RD;
                end
                else
                begin
                    if (!extra_reg && fill_reg >= len_start)
                    begin
                        len_sr_next = len_sr_reg << BW;
                    end
                    fill_next = fill_inc;
                end
            end

            ST_EMIT_RD:
            begin
                out_valid_next = 1'b1;
                out_index_next = widx_reg;
                out_last_next  = (widx_reg == words_m1);
                out_final_next = fin_reg;
                if (widx_reg == words_m1)
                begin
                    out_ctrl_next = (first_reg ? sha_pad_pkg::CMD_INIT : sha_pad_pkg::CMD_NEXT)
                                    | {core_mode_reg, 2'b00};
                end
                else
                begin
                    out_ctrl_next = sha_pad_pkg::CMD_NONE;
                end
                state_next = ST_EMIT_OUT;
            end

            ST_EMIT_OUT:
            begin
                if (m_tready)
                begin
                    out_valid_next = 1'b0;
                    if (out_last_reg)
                    begin
                        first_next = 1'b0;
                        fill_next  = '0;
                        if (fin_reg)
                        begin
                            count_next = '0;
                            first_next = 1'b1;
                            state_next = ST_IDLE;
                        end
                        else if (extra_reg)
                        begin
                            extra_next = 1'b0;
                            state_next = ST_PAD;
                        end
                        else
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                    else
                    begin
                        widx_next  = widx_reg + XW'(1);
                        state_next = ST_EMIT_RD;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Register writes: a block mode write restarts the message.
        if (cfg_we)
        begin
            if (cfg_index == sha_pad_pkg::CFG_BLOCK_MODE)
            begin
                block_mode_next = cfg_data[0];
                fill_next       = '0;
                count_next      = '0;
                first_next      = 1'b1;
            end
            else if (cfg_index == sha_pad_pkg::CFG_CORE_MODE)
            begin
                core_mode_next = cfg_data[sha_pad_pkg::CORE_MODE_W-1:0];
            end
        end
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            fill_reg       <= '0;
            count_reg      <= '0;
            first_reg      <= 1'b1;
            block_mode_reg <= 1'b0;
            core_mode_reg  <= '0;
            len_sr_reg     <= '0;
            extra_reg      <= 1'b0;
            fin_reg        <= 1'b0;
            widx_reg       <= '0;
            out_valid_reg  <= 1'b0;
            out_index_reg  <= '0;
            out_ctrl_reg   <= '0;
            out_last_reg   <= 1'b0;
            out_final_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fill_reg       <= fill_next;
            count_reg      <= count_next;
            first_reg      <= first_next;
            block_mode_reg <= block_mode_next;
            core_mode_reg  <= core_mode_next;
            len_sr_reg     <= len_sr_next;
            extra_reg      <= extra_next;
            fin_reg        <= fin_next;
            widx_reg       <= widx_next;
            out_valid_reg  <= out_valid_next;
            out_index_reg  <= out_index_next;
            out_ctrl_reg   <= out_ctrl_next;
            out_last_reg   <= out_last_next;
            out_final_reg  <= out_final_next;
        end
    end

    // Port drive.
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(sha_pad_pkg::OUT_TDATA_W - WW - XW - KW){1'b0}},
                       out_ctrl_reg, out_index_reg, out_word_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_final_reg;

    // The input side is never open while a word is on offer.
    `SPAD_ASSERT_NOW(a_ready_excl_valid, s_tready, !m_tvalid)
    // An idle block always has room for the next byte.
    `SPAD_ASSERT_NOW(a_fill_in_block, state_reg == ST_IDLE, fill_reg < blen)
    // A command rides exactly on the last word of a block.
    `SPAD_ASSERT_NOW(a_ctrl_on_last, m_tvalid, m_tlast == (out_ctrl_reg != sha_pad_pkg::CMD_NONE))
    // Delivering the length block restarts the message.
    `SPAD_ASSERT_NEXT(a_final_clears, m_tvalid && m_tready && m_tlast && m_tuser,
                      count_reg == '0 && first_reg && fill_reg == '0)

endmodule

`default_nettype wire

@@ dv/sha_pad_checker.sv @@
// Scoreboard for the SHA-2 message padder: follows the input beats and register writes,
// predicts each padded 32-bit word and compares it with the output stream.
// Depends on sha_pad_pkg; instantiated beside the block by tb_top.

module sha_pad_checker #(
    parameter int MAX_BLOCK_BYTES = sha_pad_pkg::MAX_BLOCK_BYTES_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // Input stream as seen by the block: tdata = data_byte; tuser = func.
    input  logic                                  s_tvalid,
    input  logic                                  s_tready,
    input  logic [sha_pad_pkg::DATA_W-1:0]        s_tdata,
    input  logic                                  s_tuser,
    // Output stream: tdata = word, word_index, ctrl_code, zeros; tuser = final_block.
    input  logic                                  m_tvalid,
    input  logic                                  m_tready,
    input  logic [sha_pad_pkg::OUT_TDATA_W-1:0]   m_tdata,
    input  logic                                  m_tlast,
    input  logic                                  m_tuser,
    // Register writes.
    input  logic                                  cfg_we,
    input  logic [sha_pad_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sha_pad_pkg::CFG_DATA_W-1:0]    cfg_data,
    // Results handed to the top.
    output int                                    mismatch_count,
    output int                                    words_waiting,
    output int                                    words_checked
);
    import sha_pad_pkg::*;

    localparam int NARROW_BYTES = 64;
    localparam int WIDE_BYTES   = 128;
    localparam int NARROW_LEN   = 8;
    localparam int WIDE_LEN     = 16;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic [WIDX_W-1:0] index;
        logic [CTRL_W-1:0] cmd;
        logic              block_end;
        logic              length_block;
    } pad_word_t;

    // Predicted block contents and message state.
    pad_word_t              words_due[$];
    logic [DATA_W-1:0]      block_image [0:WIDE_BYTES-1];
    int unsigned            fill_level;
    logic [COUNT_W-1:0]     byte_count;
    bit                     opening_block;
    bit                     wide_mode;
    logic [CORE_MODE_W-1:0] variant_bits;

    // The wide block is only available when the store is large enough.
    function automatic int unsigned block_bytes();
        return (wide_mode && MAX_BLOCK_BYTES >= WIDE_BYTES) ? WIDE_BYTES : NARROW_BYTES;
    endfunction

    function automatic logic [DATA_W-1:0] get_byte(input int unsigned pos);
        return (pos < MAX_BLOCK_BYTES) ? block_image[pos] : '0;
    endfunction

    task automatic put_byte(input int unsigned pos, input logic [DATA_W-1:0] value);
        if (pos < MAX_BLOCK_BYTES)
        begin
            block_image[pos] = value;
        end
    endtask

    task automatic restart_message();
        fill_level    = 0;
        byte_count    = '0;
        opening_block = 1'b1;
    endtask

    // Split the current block into big-endian words; the last one carries the command.
    task automatic queue_block(input bit with_length);
        int unsigned words;
        pad_word_t   pw;
        words = block_bytes() / 4;
        for (int unsigned w = 0; w < words; w++)
        begin
            pw.word         = {get_byte(4 * w), get_byte(4 * w + 1),
                               get_byte(4 * w + 2), get_byte(4 * w + 3)};
            pw.index        = w[WIDX_W-1:0];
            pw.block_end    = (w + 1 == words);
            pw.cmd          = pw.block_end ?
                              ((opening_block ? CMD_INIT : CMD_NEXT) | {variant_bits, 2'b00}) :
                              CMD_NONE;
            pw.length_block = with_length;
            words_due.push_back(pw);
        end
        opening_block = 1'b0;
    endtask

    // Take one input beat and queue the words it completes.
    task automatic absorb_item(input logic kind, input logic [DATA_W-1:0] value);
        int unsigned        blen;
        int unsigned        llen;
        logic [COUNT_W-1:0] bit_len;
        blen = block_bytes();
        llen = (blen == WIDE_BYTES) ? WIDE_LEN : NARROW_LEN;
        if (kind == FUNC_DATA)
        begin
            put_byte(fill_level, value);
            byte_count = byte_count + 1'b1;
            fill_level++;
            if (fill_level >= blen)
            begin
                queue_block(1'b0);
                fill_level = 0;
            end
        end
        else
        begin
            bit_len = byte_count << 3;
            put_byte(fill_level, PAD_BYTE);
            fill_level++;
            // The length field does not fit: close this block and open another.
            if (blen - fill_level < llen)
            begin
                for (int unsigned i = fill_level; i < blen; i++)
                    put_byte(i, '0);
                queue_block(1'b0);
                fill_level = 0;
            end
            for (int unsigned i = fill_level; i < blen; i++)
                put_byte(i, '0);
            // Big-endian bit length in the tail of the block.
            for (int unsigned i = 0; i < llen; i++)
                put_byte(blen - 1 - i, bit_len[8 * i +: 8]);
            queue_block(1'b1);
            restart_message();
        end
    endtask

    // Watch all three channels at each rising edge.
    always @(posedge clk or negedge rst_n)
    begin
        pad_word_t due;
        pad_word_t seen;
        if (!rst_n)
        begin
            words_due.delete();
            wide_mode      = 1'b0;
            variant_bits   = '0;
            mismatch_count = 0;
            words_checked  = 0;
            words_waiting  = 0;
            restart_message();
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_BLOCK_MODE)
                begin
                    wide_mode = cfg_data[0];
                    restart_message();
                end
                else if (cfg_index == CFG_CORE_MODE)
                begin
                    variant_bits = cfg_data[CORE_MODE_W-1:0];
                end
            end

            if (s_tvalid && s_tready)
                absorb_item(s_tuser, s_tdata);

            if (m_tvalid && m_tready)
            begin
                seen.word         = m_tdata[WORD_W-1:0];
                seen.index        = m_tdata[WORD_W +: WIDX_W];
                seen.cmd          = m_tdata[WORD_W + WIDX_W +: CTRL_W];
                seen.block_end    = m_tlast;
                seen.length_block = m_tuser;
                if (words_due.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("Unexpected output beat: word %h index %0d cmd %h last %b len %b",
                                 seen.word, seen.index, seen.cmd, seen.block_end,
                                 seen.length_block);
                end
                else
                begin
                    due = words_due.pop_front();
                    words_checked++;
                    if (due !== seen)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT)
                        begin
                            $display("Word mismatch: expected word %h index %0d cmd %h last %b len %b",
                                     due.word, due.index, due.cmd, due.block_end,
                                     due.length_block);
                            $display("               got      word %h index %0d cmd %h last %b len %b",
                                     seen.word, seen.index, seen.cmd, seen.block_end,
                                     seen.length_block);
                        end
                    end
                end
            end
            words_waiting = words_due.size();
        end
    end

endmodule

@@ dv/tb_top.sv @@
// Top of the message padder testbench: clock, reset, input beats, output stalls and verdict.
// Depends on sha_pad_pkg, sha_message_padder_unit and the sha_pad_checker scoreboard.

module tb_top;
    import sha_pad_pkg::*;

    localparam int PAD_BYTES     = MAX_BLOCK_BYTES_DEF;
    localparam int NARROW_BYTES  = 64;
    localparam int WIDE_BYTES    = 128;
    localparam int NARROW_LEN    = 8;
    localparam int WIDE_LEN      = 16;
    localparam int RANDOM_ITEMS  = 120;
    localparam int QUIET_TAIL    = 30;
    localparam int RESET_CYCLES  = 12;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 80;
    localparam int HALF_PERIOD   = 10;
    localparam int RUN_LIMIT     = 20_000_000;

    // Register indexes the block does not decode.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [DATA_W-1:0]      s_tdata   = '0;
    logic                   s_tuser   = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tlast;
    logic                   m_tuser;
    logic                   cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    int mismatch_count;
    int words_waiting;
    int words_checked;
    int items_sent    = 0;
    int messages_sent = 0;
    bit quiet         = 1'b0;   // no idling on either side
    bit bursty        = 1'b0;   // sender inserts gaps in this message
    bit wide_now      = 1'b0;   // block mode last written

    sha_message_padder_unit #(
        .MAX_BLOCK_BYTES(PAD_BYTES)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    sha_pad_checker #(
        .MAX_BLOCK_BYTES(PAD_BYTES)
    ) pad_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .m_tuser        (m_tuser),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .words_waiting  (words_waiting),
        .words_checked  (words_checked)
    );

    // Clock generation.
    initial
    begin
        forever #(HALF_PERIOD) clk = ~clk;
    end

    // Drive one input beat and hold it until the block takes it.
    task automatic send_beat(input logic kind, input logic [DATA_W-1:0] value);
        if (!quiet && bursty && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= value;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        @(negedge clk);
        items_sent++;
    endtask

    // Message bytes with random content, optionally closed by a finish beat.
    task automatic send_message(input int len, input bit with_finish);
        for (int k = 0; k < len; k++)
            send_beat(FUNC_DATA, DATA_W'($urandom_range(0, 255)));
        if (with_finish)
        begin
            send_beat(FUNC_FINISH, DATA_W'($urandom_range(0, 255)));
            messages_sent++;
        end
    endtask

    // Let every expected word drain and the block come to rest.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (words_waiting != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_BLOCK_MODE)
            wide_now = value[0];
        @(negedge clk);
    endtask

    // Output side: ready runs broken by stall bursts, always ready in the tail.
    initial
    begin
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            m_tready <= 1'b1;
            if (quiet)
            begin
                @(negedge clk);
            end
            else
            begin
                if ($urandom_range(0, 4) == 0)
                    repeat ($urandom_range(1, 120)) @(negedge clk);
                else
                    repeat ($urandom_range(1, 20)) @(negedge clk);
                if (!quiet)
                begin
                    m_tready <= 1'b0;
                    repeat ($urandom_range(1, 13)) @(negedge clk);
                end
            end
        end
    end

    // Stimulus and verdict.
    initial
    begin
        int blen;
        int llen;
        int len;
        int pick;
        int random_start;
        int batch;
        bit broken;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: empty message, byte extremes, both block sizes, spare indexes.
        bursty = 1'b1;
        write_reg(CFG_BLOCK_MODE, 2'd0);
        write_reg(CFG_CORE_MODE, 2'd0);
        send_beat(FUNC_FINISH, 8'h00);
        send_beat(FUNC_DATA, 8'h00);
        send_beat(FUNC_DATA, 8'hFF);
        send_beat(FUNC_FINISH, 8'hFF);
        wait_idle();
        write_reg(CFG_CORE_MODE, 2'd3);
        write_reg(CFG_BLOCK_MODE, 2'd3);
        send_beat(FUNC_FINISH, 8'h5A);
        send_beat(FUNC_DATA, 8'h80);
        send_beat(FUNC_DATA, 8'h7F);
        send_beat(FUNC_DATA, 8'h55);
        send_beat(FUNC_DATA, 8'hAA);
        send_beat(FUNC_FINISH, 8'h00);
        wait_idle();
        write_reg(CFG_SPARE_LO, 2'd3);
        write_reg(CFG_SPARE_HI, 2'd0);
        send_beat(FUNC_DATA, 8'h01);
        send_beat(FUNC_FINISH, 8'h00);

        // A block mode write drops the partial message.
        send_beat(FUNC_DATA, 8'h11);
        send_beat(FUNC_DATA, 8'h22);
        send_beat(FUNC_DATA, 8'h33);
        wait_idle();
        write_reg(CFG_BLOCK_MODE, 2'd0);
        send_beat(FUNC_DATA, 8'hC3);
        send_beat(FUNC_DATA, 8'h3C);
        send_beat(FUNC_FINISH, 8'h00);

        // A core mode write in the middle of a message keeps its bytes.
        send_beat(FUNC_DATA, 8'hFE);
        send_beat(FUNC_DATA, 8'h01);
        wait_idle();
        write_reg(CFG_CORE_MODE, 2'd2);
        send_beat(FUNC_FINISH, 8'hFF);
        messages_sent += 7;

        // Random phases: new settings, then a few messages of random length.
        random_start = items_sent;
        while (items_sent - random_start < RANDOM_ITEMS)
        begin
            wait_idle();
            if ($urandom_range(0, 5) == 0)
                write_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI,
                          CFG_DATA_W'($urandom_range(0, 3)));
            if ($urandom_range(0, 1) == 0)
                write_reg(CFG_BLOCK_MODE, CFG_DATA_W'($urandom_range(0, 3)));
            if ($urandom_range(0, 1) == 0)
                write_reg(CFG_CORE_MODE, CFG_DATA_W'($urandom_range(0, 3)));

            blen  = (wide_now && PAD_BYTES >= WIDE_BYTES) ? WIDE_BYTES : NARROW_BYTES;
            llen  = (blen == WIDE_BYTES) ? WIDE_LEN : NARROW_LEN;
            batch = $urandom_range(1, 3);
            for (int m = 0; m < batch; m++)
            begin
                if (items_sent - random_start >= RANDOM_ITEMS)
                    break;
                quiet  = (items_sent - random_start >= RANDOM_ITEMS - QUIET_TAIL);
                bursty = ($urandom_range(0, 2) != 0);
                pick   = $urandom_range(0, 9);
                if (pick == 5 || (pick >= 6 && pick <= 7 && !wide_now))
                begin
                    // Lengths around where the length field stops fitting or the block fills.
                    case ($urandom_range(0, 4))
                        0: len = blen - llen - 2;
                        1: len = blen - llen - 1;
                        2: len = blen - llen;
                        3: len = blen - 1;
                        default: len = blen;
                    endcase
                end
                else if (pick >= 8)
                begin
                    len = $urandom_range(0, wide_now ? 40 : blen + 4);
                end
                else
                begin
                    len = $urandom_range(0, 12);
                end
                broken = ($urandom_range(0, 9) == 0);
                send_message(len, !broken);
                if (broken)
                begin
                    // Abandon the message through a block mode write.
                    wait_idle();
                    write_reg(CFG_BLOCK_MODE, CFG_DATA_W'($urandom_range(0, 3)));
                    break;
                end
            end
        end

        quiet = 1'b1;
        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Run covered %0d input beats and %0d finished messages in both block sizes.",
                 items_sent, messages_sent);
        $display("Output words compared: %0d, mismatches: %0d, still expected: %0d.",
                 words_checked, mismatch_count, words_waiting);
        if (mismatch_count == 0 && words_waiting == 0)
            $display("sha_message_padder_unit test passed");
        else
            $display("sha_message_padder_unit test failed");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #(RUN_LIMIT);
        $display("Watchdog expired with %0d words still expected.", words_waiting);
        $display("sha_message_padder_unit test failed");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/sha_pad_pkg.sv
rtl/core/sha_message_padder_unit.sv
dv/sha_pad_checker.sv
dv/tb_top.sv
